@@ sv/kmc_pkg.sv @@
// Shared types and constants for the k-mer mismatch/indel comparator.
// No dependencies; imported by every module of the block.
package kmc_pkg;

    localparam int KMER_W     = 64;
    localparam int NUM_STAGES = 6;   // levels 0..5 of the compare pipeline
    localparam int CASC_LAST  = 4;   // last level that runs the halving cascade
    localparam int TWO_BASE   = 3;   // level of the two-base (4-bit half) rule
    localparam int FINAL_BASE = 4;   // level of the final two-base rule

    typedef logic [KMER_W-1:0] t_kmer;
    typedef logic signed [1:0] t_dir;
    typedef logic [1:0]        t_grade;

    localparam t_grade GRADE_EQUAL = 2'd0;
    localparam t_grade GRADE_ONE   = 2'd1;
    localparam t_grade GRADE_MORE  = 2'd2;

    localparam t_dir DIR_NONE  = 2'sd0;
    localparam t_dir DIR_LEFT  = 2'sd1;
    localparam t_dir DIR_RIGHT = -2'sd1;

    typedef enum logic [2:0] {
        MODE_CASC  = 3'b001,
        MODE_INDEL = 3'b010,
        MODE_DONE  = 3'b100
    } t_mode;

    typedef struct packed {
        t_mode  mode;
        t_kmer  a;
        t_kmer  b;
        t_dir   dir;
        t_grade grade;
    } t_item;

    typedef struct packed {
        logic   done;
        t_grade grade;
        t_kmer  a;
        t_kmer  b;
        t_dir   dir;
    } t_indel_res;

endpackage

@@ sv/kmc_indel_step.sv @@
// One step of the shifted (indel) match test at a fixed half width.
// Depends on kmc_pkg.
module kmc_indel_step
    import kmc_pkg::*;
#(
    parameter int HALF = 32
) (
    input  t_kmer      i_a,
    input  t_kmer      i_b,
    input  t_dir       i_dir,
    output t_indel_res o_res
);

    localparam t_kmer WIN  = (t_kmer'(1) << HALF) - t_kmer'(1);
    localparam t_kmer FULL = WIN | (WIN << (HALF - 2));

    logic dle, dge;
    logic m_a, m_b, c1, c2, c3, c4;

    always_comb begin
        dle = (i_dir != DIR_LEFT);
        dge = (i_dir != DIR_RIGHT);
        // whole-window matches with a one-base shift
        m_a = dle && ((i_a >> 2) == (i_b & FULL));
        m_b = dge && ((i_b >> 2) == (i_a & FULL));
        // half-window matches pick the side to follow
        c1 = dle && (((i_a >> 2) & WIN) == (i_b & WIN));
        c2 = dle && (((i_a >> (HALF - 2)) & WIN) == (i_b >> HALF));
        c3 = dge && (((i_b >> 2) & WIN) == (i_a & WIN));
        c4 = dge && (((i_b >> (HALF - 2)) & WIN) == (i_a >> HALF));

        o_res.done  = 1'b0;
        o_res.grade = GRADE_ONE;
        o_res.a     = i_a;
        o_res.b     = i_b;
        o_res.dir   = i_dir;
        if (m_a || m_b) begin
            o_res.done = 1'b1;
        end else if (c1) begin
            o_res.dir = i_dir + DIR_LEFT;
            o_res.a   = i_a >> (HALF + 2);
            o_res.b   = i_b >> HALF;
        end else if (c2) begin
            o_res.dir = i_dir + DIR_LEFT;
            o_res.a   = i_a & (WIN >> 2);
            o_res.b   = i_b & WIN;
        end else if (c3) begin
            o_res.dir = i_dir + DIR_RIGHT;
            o_res.b   = i_b >> (HALF + 2);
            o_res.a   = i_a >> HALF;
        end else if (c4) begin
            o_res.dir = i_dir + DIR_RIGHT;
            o_res.b   = i_b & (WIN >> 2);
            o_res.a   = i_a & WIN;
        end else begin
            o_res.done  = 1'b1;
            o_res.grade = GRADE_MORE;
        end
    end

endmodule

@@ sv/kmc_stage.sv @@
// One registered level of the compare pipeline: a cascade level and/or an indel step.
// Depends on kmc_pkg and kmc_indel_step.
module kmc_stage
    import kmc_pkg::*;
#(
    parameter int LEVEL = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    t_item w_casc, w_indel, n_item, r_item;
    logic  r_valid;

    // ---- halving cascade ----
    generate
        if (LEVEL < TWO_BASE) begin : g_half
            localparam int    H    = 32 >> LEVEL;
            localparam t_kmer LO   = (t_kmer'(1) << H) - t_kmer'(1);
            localparam t_kmer KEEP = (LEVEL == 0) ? {KMER_W{1'b1}}
                                                  : (t_kmer'(1) << (2 * H)) - t_kmer'(1);
            t_kmer am, bm;
            always_comb begin
                am     = i_item.a & KEEP;
                bm     = i_item.b & KEEP;
                w_casc = i_item;
                if (LEVEL == 0 && i_item.a == i_item.b) begin
                    w_casc.mode  = MODE_DONE;
                    w_casc.grade = GRADE_EQUAL;
                end else if ((i_item.a & LO) == (i_item.b & LO)) begin
                    w_casc.a = i_item.a >> H;
                    w_casc.b = i_item.b >> H;
                end else if ((i_item.a >> H) != (i_item.b >> H)) begin
                    w_casc.a   = am;
                    w_casc.b   = bm;
                    w_casc.dir = DIR_NONE;
                    if (am == bm) begin
                        w_casc.mode  = MODE_DONE;
                        w_casc.grade = GRADE_EQUAL;
                    end else begin
                        w_casc.mode = MODE_INDEL;
                    end
                end
            end
        end else if (LEVEL == TWO_BASE) begin : g_two
            t_kmer am, bm;
            always_comb begin
                am     = i_item.a & t_kmer'(255);
                bm     = i_item.b & t_kmer'(255);
                w_casc = i_item;
                if ((i_item.a & t_kmer'(15)) == (i_item.b & t_kmer'(15))) begin
                    w_casc.mode  = MODE_DONE;
                    w_casc.grade = {1'b0, (i_item.a >> 6) != (i_item.b >> 6)}
                                 + {1'b0, (i_item.a & t_kmer'(48)) != (i_item.b & t_kmer'(48))};
                end else if ((i_item.a >> 4) != (i_item.b >> 4)) begin
                    w_casc.a   = am;
                    w_casc.b   = bm;
                    w_casc.dir = DIR_NONE;
                    if (am == bm) begin
                        w_casc.mode  = MODE_DONE;
                        w_casc.grade = GRADE_EQUAL;
                    end else begin
                        w_casc.mode = MODE_INDEL;
                    end
                end
            end
        end else if (LEVEL == FINAL_BASE) begin : g_final
            // either base agrees in place or crosswise; high bits are left unmasked
            logic hit;
            always_comb begin
                hit = ((i_item.a >> 2) == (i_item.b >> 2))
                   || ((i_item.a & t_kmer'(3)) == (i_item.b & t_kmer'(3)))
                   || ((i_item.a >> 2) == (i_item.b & t_kmer'(3)))
                   || ((i_item.a & t_kmer'(3)) == (i_item.b >> 2));
                w_casc       = i_item;
                w_casc.mode  = MODE_DONE;
                w_casc.grade = hit ? GRADE_ONE : GRADE_MORE;
            end
        end else begin : g_no_casc
            assign w_casc = i_item;
        end
    endgenerate

    // ---- indel step, one half behind the cascade ----
    generate
        if (LEVEL >= 1) begin : g_indel
            t_indel_res w_res;
            kmc_indel_step #(
                .HALF (32 >> (LEVEL - 1))
            ) u_step (
                .i_a   (i_item.a),
                .i_b   (i_item.b),
                .i_dir (i_item.dir),
                .o_res (w_res)
            );
            always_comb begin
                w_indel       = i_item;
                w_indel.a     = w_res.a;
                w_indel.b     = w_res.b;
                w_indel.dir   = w_res.dir;
                w_indel.grade = w_res.grade;
                // surviving the last step also grades as one difference
                if (w_res.done || LEVEL == NUM_STAGES - 1) begin
                    w_indel.mode = MODE_DONE;
                end
            end
        end else begin : g_no_indel
            assign w_indel = i_item;
        end
    endgenerate

    always_comb begin
        case (i_item.mode)
            MODE_CASC:  n_item = w_casc;
            MODE_INDEL: n_item = w_indel;
            default:    n_item = i_item;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ sv/kmer_mismatch_indel_compare.sv @@
// Top level of the k-mer mismatch/indel comparator.
// Depends on kmc_pkg and kmc_stage.
//
// Grades a pair of 32-base k-mers (2 bits per base) as 0 equal, 1 one
// substitution or shifted indel, 2 more. One pair is taken on every cycle
// with i_start high; o_busy is never raised. The grade appears on
// o_edit_grade with o_valid high for one cycle, after an input register
// and six compare levels (halving cascade over 32/16/8/4/2-bit halves, the
// indel test trailing one level behind), each registered. Results cannot be
// held off and must be taken when strobed.
module kmer_mismatch_indel_compare
    import kmc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    output logic   o_busy,
    input  t_kmer  i_target_kmer,
    input  t_kmer  i_query_kmer,
    output logic   o_valid,
    output t_grade o_edit_grade
);

    logic  n_in_valid, r_in_valid;
    t_kmer r_in_a, r_in_b;

    logic  w_valid [0:NUM_STAGES];
    t_item w_item  [0:NUM_STAGES];

    assign o_busy     = 1'b0;
    assign n_in_valid = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        r_in_a <= i_target_kmer;
        r_in_b <= i_query_kmer;
    end

    always_comb begin
        w_valid[0]      = r_in_valid;
        w_item[0].mode  = MODE_CASC;
        w_item[0].a     = r_in_a;
        w_item[0].b     = r_in_b;
        w_item[0].dir   = DIR_NONE;
        w_item[0].grade = GRADE_EQUAL;
    end

    generate
        for (genvar k = 0; k < NUM_STAGES; k++) begin : g_lvl
            kmc_stage #(
                .LEVEL (k)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .i_item  (w_item[k]),
                .o_valid (w_valid[k+1]),
                .o_item  (w_item[k+1])
            );
        end
    endgenerate

    assign o_valid      = w_valid[NUM_STAGES];
    assign o_edit_grade = w_item[NUM_STAGES].grade;

    // every transfer comes out at the end of the pipeline, and nothing else does
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##7 o_valid)
        else $error("accepted pair produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 7))
        else $error("result without a matching start");

    a_resolved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_item[NUM_STAGES].mode == MODE_DONE))
        else $error("item left the pipeline unresolved");

endmodule
